// File: sv/geq_pkg.sv
// ----------------------------------------------------------------------------
// geq_pkg: gamepad event queue shared types and constants
// Request structs, configuration indexes, reset values and stick helpers.
// ----------------------------------------------------------------------------
package geq_pkg;

    localparam int Players    = 4;
    localparam int Slots      = 8;
    localparam int PlayerBits = $clog2(Players);
    localparam int SlotBits   = $clog2(Slots);
    localparam int HistDepth  = Players * Slots;
    localparam int HistAddrW  = $clog2(HistDepth);
    localparam int StickDepth = 2 * Players;
    localparam int StickAddrW = $clog2(StickDepth);
    localparam int HistW      = 64;
    localparam int StickW     = 64;

    localparam logic [14:0] ThresholdReset = 15'h7332;
    localparam logic [15:0] DelayReset     = 16'h00fa;
    localparam logic [15:0] AxisMax        = 16'h7fff;
    localparam logic [15:0] AxisMin        = 16'h8000;

    typedef enum logic [1:0] {
        FUNC_DISPATCH = 2'd0,
        FUNC_FETCH    = 2'd1,
        FUNC_FLUSH    = 2'd2,
        FUNC_NONE     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_SUPPRESSED = 2'd0,
        CFG_ENABLED    = 2'd1,
        CFG_THRESHOLD  = 2'd2,
        CFG_DELAY      = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_STICK_RD,
        ST_STICK_EV,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SHIFT_LAST,
        ST_FETCH_RD,
        ST_FETCH_EV,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         player;
        logic [15:0]        event_kind;
        logic signed [15:0] data_x;
        logic signed [15:0] data_y;
        logic [31:0]        now_ms;
    } t_req;

    typedef struct packed {
        logic               found;
        logic               recorded;
        logic [15:0]        out_kind;
        logic [1:0]         out_player;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [31:0]        last_event_ms;
    } t_rsp;

    // absolute value of a 16-bit axis, 17 bits so that -32768 gives 32768
    function automatic logic [16:0] axis_mag(input logic [15:0] v);
        logic [16:0] s;
        s = {v[15], v};
        return v[15] ? (17'd0 - s) : s;
    endfunction

    function automatic logic axis_pushed(input logic [15:0] v, input logic [14:0] thr);
        return axis_mag(v) >= {2'b00, thr};
    endfunction

endpackage

// File: sv/geq_ram.sv
// ----------------------------------------------------------------------------
// geq_ram: generic single-port RAM
// One access per cycle, registered read data; a write also reads the old word.
// ----------------------------------------------------------------------------
module geq_ram #(
    parameter int Width = 64,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: sv/gamepad_event_queue_autorepeat_core.sv
// ----------------------------------------------------------------------------
// gamepad_event_queue_autorepeat_core
// Per-player event history with stick threshold filtering and auto-repeat.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  request | i_req_valid, o_req_stall, i_req  | in
//  result  | o_rsp_valid, i_rsp_stall, o_rsp  | out
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data  | in
//
//  One request at a time. Every history access goes through the single
//  history RAM port: a stick dispatch first reads and rewrites its stick
//  RAM word, a dispatch walks the shift (a read and a write per slot) and
//  writes the new entry, fetch reads slots newest first and flush clears
//  each history entry in turn; DONE then loads the result. After reset a
//  clearing pass zeroes both RAMs before the first request is taken. The
//  result sits in an output register; the next request is taken as it waits.
// ----------------------------------------------------------------------------
module gamepad_event_queue_autorepeat_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  geq_pkg::t_req   i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output geq_pkg::t_rsp   o_rsp,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);
    import geq_pkg::*;

    // configuration
    logic        r_suppressed, r_enabled;
    logic [14:0] r_thr;
    logic [15:0] r_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppressed <= 1'b0;
            r_enabled    <= 1'b1;
            r_thr        <= ThresholdReset;
            r_delay      <= DelayReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SUPPRESSED: r_suppressed <= i_cfg_data[0];
                CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                CFG_THRESHOLD:  r_thr        <= i_cfg_data[14:0];
                CFG_DELAY:      r_delay      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state
    t_state r_st, n_st;
    t_req   r_req;
    logic [HistAddrW-1:0]  r_cnt;       // clear / flush sweep
    logic [SlotBits-1:0]   r_slot;      // slot walk
    logic [PlayerBits-1:0] r_pl;        // player under work
    logic                  r_any;       // any-player fetch
    logic [31:0]           r_last;
    logic                  r_found, r_rec;
    logic [HistW-1:0]      r_ev;        // entry being written / fetched
    logic                  r_out_v;
    t_rsp                  r_out;

    // RAM ports
    logic                  h_we, s_we;
    logic [HistAddrW-1:0]  h_addr;
    logic [StickAddrW-1:0] s_addr;
    logic [HistW-1:0]      h_wdata, h_rdata;
    logic [StickW-1:0]     s_wdata, s_rdata;

    geq_ram #(.Width(HistW), .Depth(HistDepth)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_addr(h_addr), .i_wdata(h_wdata), .o_rdata(h_rdata));
    geq_ram #(.Width(StickW), .Depth(StickDepth)) u_stick (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wdata), .o_rdata(s_rdata));

    logic take;
    assign o_req_stall = (r_st != ST_IDLE);
    assign take        = i_req_valid && !o_req_stall;

    // stick decision, from the stick RAM word {stamp, prev_y, prev_x}
    logic        st_px, st_py, st_rec;
    logic [15:0] st_x, st_y, prev_x, prev_y;
    logic [31:0] st_stamp, st_age;
    always_comb begin
        prev_x   = s_rdata[15:0];
        prev_y   = s_rdata[31:16];
        st_stamp = s_rdata[63:32];
        st_age   = r_req.now_ms - st_stamp;
        st_px    = axis_pushed(r_req.data_x, r_thr);
        st_py    = axis_pushed(r_req.data_y, r_thr);
        priority if (!st_px && !st_py)                     st_rec = 1'b0;
        else if (st_px && !axis_pushed(prev_x, r_thr))     st_rec = 1'b1;
        else if (st_py && !axis_pushed(prev_y, r_thr))     st_rec = 1'b1;
        else                                               st_rec = st_age >= {16'd0, r_delay};
        st_x = (st_rec && st_px) ? (r_req.data_x[15] ? AxisMin : AxisMax) : r_req.data_x;
        st_y = (st_rec && st_py) ? (r_req.data_y[15] ? AxisMin : AxisMax) : r_req.data_y;
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLEAR: if (r_cnt == HistAddrW'(HistDepth - 1)) n_st = ST_IDLE;
            ST_IDLE: begin
                if (take) begin
                    unique case (t_func'(i_req.func))
                        FUNC_DISPATCH: begin
                            if (r_suppressed || i_req.player >= 3'(Players)) n_st = ST_DONE;
                            else if (i_req.event_kind == 16'd1 || i_req.event_kind == 16'd2)
                                n_st = ST_STICK_RD;
                            else n_st = ST_SHIFT_RD;
                        end
                        FUNC_FETCH: n_st = r_enabled ? ST_FETCH_RD : ST_DONE;
                        FUNC_FLUSH: n_st = ST_FLUSH;
                        default:    n_st = ST_DONE;
                    endcase
                end
            end
            ST_STICK_RD: n_st = ST_STICK_EV;
            ST_STICK_EV: n_st = st_rec ? ST_SHIFT_RD : ST_DONE;
            ST_SHIFT_RD: n_st = ST_SHIFT_WR;
            // last move copies slot Slots-1 down; the new entry then lands in slot Slots-1
            ST_SHIFT_WR: n_st = (r_slot == SlotBits'(Slots - 2)) ? ST_SHIFT_LAST : ST_SHIFT_RD;
            ST_SHIFT_LAST: n_st = ST_DONE;
            ST_FETCH_RD: n_st = ST_FETCH_EV;
            ST_FETCH_EV: begin
                if (h_rdata[15:0] != 16'd0) n_st = ST_DONE;
                else if (r_slot != '0) n_st = ST_FETCH_RD;
                else if (r_any && r_pl != PlayerBits'(Players - 1)) n_st = ST_FETCH_RD;
                else n_st = ST_DONE;
            end
            ST_FLUSH: if (r_cnt == HistAddrW'(HistDepth - 1)) n_st = ST_DONE;
            ST_DONE: if (!r_out_v || !i_rsp_stall) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // RAM control
    logic [HistAddrW-1:0] cur_addr;
    assign cur_addr = HistAddrW'({r_pl, r_slot});
    always_comb begin
        h_we = 1'b0; h_addr = cur_addr; h_wdata = '0;
        s_we = 1'b0; s_addr = StickAddrW'({~(r_req.event_kind == 16'd1), r_pl});
        s_wdata = '0;
        unique case (r_st)
            ST_CLEAR: begin
                h_we = 1'b1; h_addr = r_cnt;
                s_we = 1'b1; s_addr = r_cnt[StickAddrW-1:0];
            end
            ST_FLUSH: begin h_we = 1'b1; h_addr = r_cnt; end
            ST_STICK_EV: begin
                s_we    = 1'b1;
                s_wdata = {st_rec ? r_req.now_ms : st_stamp, st_y, st_x};
            end
            ST_SHIFT_RD: h_addr = HistAddrW'({r_pl, SlotBits'(r_slot + 1'b1)});
            ST_SHIFT_WR: begin h_we = 1'b1; h_wdata = h_rdata; end
            ST_SHIFT_LAST: begin h_we = 1'b1; h_wdata = r_ev; end
            ST_FETCH_EV: begin
                h_we    = (h_rdata[15:0] != 16'd0);
                h_wdata = {h_rdata[63:16], 16'd0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLEAR;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
            r_last  <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                ST_CLEAR, ST_FLUSH: r_cnt <= r_cnt + 1'b1;
                ST_IDLE: begin
                    r_cnt   <= '0;
                    r_req   <= i_req;
                    r_pl    <= (i_req.player >= 3'(Players)) ? '0 : i_req.player[PlayerBits-1:0];
                    r_any   <= (i_req.player >= 3'(Players));
                    r_found <= 1'b0;
                    r_rec   <= 1'b0;
                    r_ev    <= {i_req.data_y, i_req.data_x, 16'(i_req.player), i_req.event_kind};
                    r_slot  <= (i_req.func == FUNC_FETCH) ? SlotBits'(Slots - 1) : '0;
                end
                ST_STICK_EV: r_ev[63:32] <= {st_y, st_x};
                default: ;
            endcase
            if (r_st == ST_SHIFT_WR) r_slot <= r_slot + 1'b1;
            if (r_st == ST_SHIFT_LAST) begin
                r_rec <= 1'b1;
                if (r_req.event_kind != 16'd0) r_last <= r_req.now_ms;
            end
            if (r_st == ST_FETCH_EV) begin
                if (h_rdata[15:0] != 16'd0) begin
                    r_found <= 1'b1;
                    r_ev    <= h_rdata;
                end else if (r_slot != '0) begin
                    r_slot <= r_slot - 1'b1;
                end else begin
                    r_slot <= SlotBits'(Slots - 1);
                    r_pl   <= r_pl + 1'b1;
                end
            end
            if (r_st == ST_DONE && (!r_out_v || !i_rsp_stall)) begin
                r_out_v <= 1'b1;
                r_out   <= '{found: r_found, recorded: r_rec,
                             out_kind: r_found ? r_ev[15:0] : '0,
                             out_player: r_found ? r_ev[17:16] : '0,
                             out_x: r_found ? r_ev[47:32] : '0,
                             out_y: r_found ? r_ev[63:48] : '0,
                             last_event_ms: r_last};
            end else if (r_out_v && !i_rsp_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_v;
    assign o_rsp       = r_out;

    // a request is only taken from idle, and a stalled result is held unchanged
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_req_stall) else $error("request taken while busy");
    a_rec_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.recorded) |-> !o_rsp.found) else $error("recorded on fetch");
    a_found_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.found) |-> (o_rsp.out_kind != 16'd0)) else $error("empty found");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_rsp_valid) && $past(i_rsp_stall)) |-> (o_rsp_valid && $stable(o_rsp)))
        else $error("result lost under stall");
endmodule

// File: bench/tb_gamepad_event_queue_autorepeat_core.sv
// ----------------------------------------------------------------------------
// tb_gamepad_event_queue_autorepeat_core: self-checking bench for the core
// Drives dispatch, fetch and flush requests, predicts each result in
// the bench and compares every returned result as a whole.
// ----------------------------------------------------------------------------
module tb_gamepad_event_queue_autorepeat_core;
    import geq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_stall;
    t_req        i_req = '0;
    logic        o_rsp_valid;
    logic        i_rsp_stall = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    gamepad_event_queue_autorepeat_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: a mirror of the block's history and stick tracking
    // ------------------------------------------------------------------------
    logic [63:0]        hist [HistDepth];
    logic signed [15:0] last_x [StickDepth];
    logic signed [15:0] last_y [StickDepth];
    logic [31:0]        rep_ms [StickDepth];
    logic [31:0]        last_ms;
    logic               cfg_supp;
    logic               cfg_en;
    logic [14:0]        cfg_thr;
    logic [15:0]        cfg_delay;

    t_rsp    pending_rsp [$];
    int      errors = 0;
    int      n_rsp = 0;
    int      n_found = 0;
    int      idle_tx = 0;     // sender idle percentage
    int      idle_rx = 0;     // receiver stall percentage
    int      quiet = 0;
    logic [31:0] clock_ms = 0;

    function automatic logic pushed(logic signed [15:0] v);
        // 17-bit magnitude so -32768 is 32768
        logic signed [16:0] w;
        w = 17'(v);
        if (w < 0) w = -w;
        return w >= $signed({2'b00, cfg_thr});
    endfunction

    function automatic logic signed [15:0] saturate(logic signed [15:0] v);
        if (!pushed(v)) return v;
        return v[15] ? 16'sh8000 : 16'sh7fff;
    endfunction

    // Fetch newest nonzero slot of one player; clears its kind.
    function automatic logic take_newest(int p, output logic [63:0] e);
        int i;
        e = '0;
        for (i = Slots - 1; i >= 0; i--) begin
            if (hist[p*Slots+i][15:0] != 0) begin
                e = hist[p*Slots+i];
                hist[p*Slots+i][15:0] = '0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_rsp queue_model(t_req r);
        t_rsp o;
        logic [63:0] e;
        logic rec;
        logic px, py;
        logic signed [15:0] x, y;
        int k, i, q;
        o = '0;
        e = '0;
        x = r.data_x;
        y = r.data_y;
        case (t_func'(r.func))
            FUNC_DISPATCH: begin
                if (!cfg_supp && r.player < Players) begin
                    rec = 1'b1;
                    if (r.event_kind == 1 || r.event_kind == 2) begin
                        k = (r.event_kind - 1) * Players + r.player;
                        px = pushed(x);
                        py = pushed(y);
                        if (!px && !py) rec = 1'b0;
                        else if (px && !pushed(last_x[k])) rec = 1'b1;
                        else if (py && !pushed(last_y[k])) rec = 1'b1;
                        else rec = (r.now_ms - rep_ms[k]) >= {16'd0, cfg_delay};
                        if (rec) begin
                            rep_ms[k] = r.now_ms;
                            x = saturate(x);
                            y = saturate(y);
                        end
                        last_x[k] = x;
                        last_y[k] = y;
                    end
                    if (rec) begin
                        for (i = 0; i < Slots - 1; i++)
                            hist[r.player*Slots+i] = hist[r.player*Slots+i+1];
                        hist[r.player*Slots+Slots-1] =
                            {y, x, 13'd0, r.player, r.event_kind};
                        if (r.event_kind != 0) last_ms = r.now_ms;
                        o.recorded = 1'b1;
                    end
                end
            end
            FUNC_FETCH: begin
                if (cfg_en) begin
                    if (r.player < Players) o.found = take_newest(r.player, e);
                    else
                        for (q = 0; q < Players && !o.found; q++)
                            o.found = take_newest(q, e);
                end
            end
            FUNC_FLUSH: for (i = 0; i < HistDepth; i++) hist[i] = '0;
            default: ;
        endcase
        if (o.found) begin
            o.out_kind   = e[15:0];
            o.out_player = e[17:16];
            o.out_x      = e[47:32];
            o.out_y      = e[63:48];
        end
        o.last_event_ms = last_ms;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (o_rsp_valid && !i_rsp_stall && i_rst_n) begin
            n_rsp <= n_rsp + 1;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_rsp);
                errors <= errors + 1;
            end else begin
                want = pending_rsp.pop_front();
                if (want !== o_rsp) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, o_rsp);
                    errors <= errors + 1;
                end
            end
        end
        i_rsp_stall <= ($urandom_range(99) < idle_rx);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_request(t_req r);
        while ($urandom_range(99) < idle_tx) @(posedge i_clk);
        i_req <= r;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        pending_rsp.push_back(queue_model(r));
        i_req_valid <= 1'b0;
        // the block is busy after taking a request
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SUPPRESSED: cfg_supp  = v[0];
            CFG_ENABLED:    cfg_en    = v[0];
            CFG_THRESHOLD:  cfg_thr   = v[14:0];
            CFG_DELAY:      cfg_delay = v;
        endcase
    endtask

    function automatic t_req mk(t_func f, int p, logic [15:0] k,
                                logic [15:0] x, logic [15:0] y, logic [31:0] t);
        t_req r;
        r.func = f; r.player = 3'(p); r.event_kind = k;
        r.data_x = x; r.data_y = y; r.now_ms = t;
        return r;
    endfunction

    // random axis biased toward the threshold region and the extremes
    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(40));
            3: return 16'({1'b0, cfg_thr} + $urandom_range(4) - 2);
            4: return 16'(-({1'b0, cfg_thr} + $urandom_range(4) - 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req rand_request();
        t_req r;
        int sel;
        sel = $urandom_range(99);
        clock_ms += $urandom_range(3) == 0 ? $urandom : $urandom_range(300);
        r.now_ms = clock_ms;
        r.player = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                            : 3'($urandom_range(Players-1));
        r.data_x = rand_axis();
        r.data_y = rand_axis();
        r.event_kind = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
        if ($urandom_range(19) == 0) r.event_kind = 0;
        if (sel < 55)      r.func = FUNC_DISPATCH;
        else if (sel < 93) r.func = FUNC_FETCH;
        else if (sel < 96) r.func = FUNC_FLUSH;
        else               r.func = FUNC_NONE;
        if (r.func == FUNC_FETCH && $urandom_range(3) == 0) r.player = 3'(Players);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed;
        send_request(mk(FUNC_FETCH, 0, 0, 0, 0, 0));               // empty history
        send_request(mk(FUNC_DISPATCH, 0, 3, 16'h0105, 16'h7fff, 10));
        send_request(mk(FUNC_DISPATCH, 0, 0, 1, 2, 11));           // empty kind
        send_request(mk(FUNC_DISPATCH, 1, 1, 16'h8000, 0, 20));    // negative full scale
        send_request(mk(FUNC_DISPATCH, 1, 1, 16'h8000, 0, 30));    // held, too soon
        send_request(mk(FUNC_DISPATCH, 1, 1, 16'h8000, 0, 400));   // held, repeat due
        send_request(mk(FUNC_DISPATCH, 1, 2, 5, 16'hfffb, 401));   // dropped, inside
        send_request(mk(FUNC_DISPATCH, 1, 2, 16'h7332, 0, 402));   // at threshold
        send_request(mk(FUNC_DISPATCH, 1, 2, 16'h7332, 16'h8ccf, 403)); // y just inside threshold
        send_request(mk(FUNC_DISPATCH, 5, 3, 1, 1, 404));          // bad player
        send_request(mk(FUNC_DISPATCH, 3, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff));
        send_request(mk(FUNC_NONE, 7, 16'hffff, 16'hffff, 16'hffff, 0));
        send_request(mk(FUNC_FETCH, 0, 0, 0, 0, 0));
        send_request(mk(FUNC_FETCH, Players, 0, 0, 0, 0));         // any player
        send_request(mk(FUNC_FETCH, 7, 0, 0, 0, 0));
        send_request(mk(FUNC_FETCH, 3, 0, 0, 0, 0));
        send_request(mk(FUNC_FLUSH, 0, 0, 0, 0, 0));
        send_request(mk(FUNC_FETCH, Players, 0, 0, 0, 0));
        write_reg(CFG_SUPPRESSED, 1);
        send_request(mk(FUNC_DISPATCH, 0, 3, 1, 1, 500));          // suppressed
        write_reg(CFG_SUPPRESSED, 0);
        send_request(mk(FUNC_DISPATCH, 0, 3, 1, 1, 501));
        write_reg(CFG_ENABLED, 0);
        send_request(mk(FUNC_FETCH, 0, 0, 0, 0, 0));               // disabled fetch
        write_reg(CFG_ENABLED, 1);
        send_request(mk(FUNC_FETCH, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            send_request(rand_request());
            if ($urandom_range(299) == 0) drain();   // sender waits for all results
        end
    endtask

    // random phases under several register settings, extremes included
    task automatic test_settings(int per);
        write_reg(CFG_THRESHOLD, 0);        write_reg(CFG_DELAY, 0);
        test_random(per);
        write_reg(CFG_THRESHOLD, 16'h7fff); write_reg(CFG_DELAY, 16'hffff);
        test_random(per);
        write_reg(CFG_THRESHOLD, 1000);     write_reg(CFG_DELAY, 100);
        test_random(per);
        write_reg(CFG_SUPPRESSED, 1);
        test_random(per / 8);
        write_reg(CFG_SUPPRESSED, 0);       write_reg(CFG_ENABLED, 0);
        test_random(per / 8);
        write_reg(CFG_ENABLED, 1);
        write_reg(CFG_THRESHOLD, ThresholdReset); write_reg(CFG_DELAY, DelayReset);
        test_random(per);
    endtask

    initial begin
        foreach (hist[i]) hist[i] = '0;
        foreach (last_x[i]) begin
            last_x[i] = 0; last_y[i] = 0; rep_ms[i] = 0;
        end
        last_ms = 0;
        cfg_supp = 0; cfg_en = 1; cfg_thr = ThresholdReset; cfg_delay = DelayReset;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_tx = 20; idle_rx = 73;
        test_directed();
        test_settings(120);
        idle_tx = 73; idle_rx = 20;
        test_settings(120);
        idle_tx = 0; idle_rx = 0;
        test_settings(120);

        drain();
        $display("Covered %0d results (%0d found), dispatch/fetch/flush under",
                 n_rsp, n_found);
        $display("varied thresholds, delays, suppress/enable and stall patterns.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(posedge i_clk)
        if (o_rsp_valid && !i_rsp_stall && o_rsp.found) n_found <= n_found + 1;

endmodule
